// File: hw/rtl/pwt_pkg.sv
// ============================================================================
// pwt_pkg: shared types and constants of the protobuf wire tokenizer
// Result kinds, error codes, parser phases and the front-to-back queue entry.
// ============================================================================
package pwt_pkg;

    localparam int MAX_MSG_BYTES = 65536;
    localparam int REM_W         = $clog2(MAX_MSG_BYTES + 1);

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [3:0] VARINT_LAST_IDX = 4'd9;

    localparam logic [2:0] WT_VARINT = 3'd0;
    localparam logic [2:0] WT_I64    = 3'd1;
    localparam logic [2:0] WT_LEN    = 3'd2;
    localparam logic [2:0] WT_I32    = 3'd5;

    localparam logic [REM_W-1:0] SKIP_I64 = REM_W'(8);
    localparam logic [REM_W-1:0] SKIP_I32 = REM_W'(4);

    typedef enum logic [2:0] {
        K_VARINT  = 3'd0,
        K_LENGTH  = 3'd1,
        K_PAYLOAD = 3'd2,
        K_FIXED   = 3'd3,
        K_END_OK  = 3'd4,
        K_ERROR   = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        E_TOO_LONG  = 2'd0,
        E_BAD_WIRE  = 2'd1,
        E_TRUNCATED = 2'd2
    } t_err;

    typedef enum logic [2:0] {
        PH_TAG     = 3'd0,
        PH_VALUE   = 3'd1,
        PH_LENGTH  = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_SKIP    = 3'd4
    } t_phase;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] tag_field;
        logic [2:0]  tag_wire;
        logic [63:0] value;
        logic [7:0]  payload_byte;
        logic        payload_last;
        t_err        error_code;
        logic        run_last;
    } t_result;

    // One queue entry carries everything a single input byte causes.
    typedef struct packed {
        logic    has_pri;
        t_result pri;
        logic    has_end;
        logic    end_ok;
    } t_entry;

endpackage

// File: hw/rtl/pwt_if.sv
// ============================================================================
// pwt_if: byte and result channels of the protobuf wire tokenizer
// Valid/ready channels; an item moves when valid and ready are both high.
// ============================================================================
interface pwt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_in_message;

    modport source (output valid, output data_byte, output last_in_message, input ready);
    modport sink   (input valid, input data_byte, input last_in_message, output ready);
endinterface

interface pwt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [31:0] tag_field;
    logic [2:0]  tag_wire;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        payload_last;
    logic [1:0]  error_code;
    logic        run_last;

    modport source (output valid, output kind, output tag_field, output tag_wire,
                    output value, output payload_byte, output payload_last,
                    output error_code, output run_last, input ready);
    modport sink   (input valid, input kind, input tag_field, input tag_wire,
                    input value, input payload_byte, input payload_last,
                    input error_code, input run_last, output ready);
endinterface

// File: hw/rtl/pwt_front.sv
// ============================================================================
// pwt_front: byte parser of the protobuf wire tokenizer
// Takes one byte a cycle unless the queue is full, updates the parse state and queues its results.
// ============================================================================
module pwt_front
    import pwt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    pwt_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output t_entry        o_entry
);

    t_phase             r_phase, n_phase;
    logic [63:0]        r_acc, n_acc;
    logic [3:0]         r_cnt, n_cnt;
    logic [31:0]        r_field, n_field;
    logic [2:0]         r_wire, n_wire;
    logic [REM_W-1:0]   r_remain, n_remain;
    logic               r_stopped, n_stopped;

    logic               accept;
    logic [6:0]         shamt;
    logic [63:0]        acc_new;
    logic [REM_W-1:0]   rem_dec;
    logic [7:0]         b;
    logic               done;
    t_result            pri;
    logic               pri_valid;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign b          = i_in.data_byte;
    assign shamt      = 7'(r_cnt) * 7'd7;
    assign acc_new    = r_acc | (64'(b[6:0]) << shamt);
    assign rem_dec    = (r_remain != '0) ? r_remain - REM_W'(1) : '0;

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        n_field   = r_field;
        n_wire    = r_wire;
        n_remain  = r_remain;
        n_stopped = r_stopped;
        pri       = '0;
        pri_valid = 1'b0;
        done      = 1'b0;

        if (!r_stopped) begin
            case (r_phase)
                PH_TAG, PH_VALUE, PH_LENGTH: begin
                    if (!b[7]) begin
                        done  = 1'b1;
                        n_acc = '0;
                        n_cnt = '0;
                    end else if (r_cnt >= VARINT_LAST_IDX) begin
                        n_acc          = '0;
                        n_cnt          = '0;
                        pri_valid      = 1'b1;
                        pri.kind       = K_ERROR;
                        pri.error_code = E_TOO_LONG;
                        n_stopped      = 1'b1;
                    end else begin
                        n_acc = acc_new;
                        n_cnt = r_cnt + 4'd1;
                    end
                    if (done) begin
                        if (r_phase == PH_TAG) begin
                            n_field = acc_new[34:3];
                            n_wire  = acc_new[2:0];
                            if (acc_new[34:3] == '0) begin
                                pri_valid = 1'b1;
                                pri.kind  = K_END_OK;
                                n_stopped = 1'b1;
                            end else if (acc_new[2:0] == WT_VARINT) begin
                                n_phase = PH_VALUE;
                            end else if (acc_new[2:0] == WT_LEN) begin
                                n_phase = PH_LENGTH;
                            end else if (acc_new[2:0] == WT_I64) begin
                                n_remain = SKIP_I64;
                                n_phase  = PH_SKIP;
                            end else if (acc_new[2:0] == WT_I32) begin
                                n_remain = SKIP_I32;
                                n_phase  = PH_SKIP;
                            end else begin
                                pri_valid      = 1'b1;
                                pri.kind       = K_ERROR;
                                pri.error_code = E_BAD_WIRE;
                                n_stopped      = 1'b1;
                            end
                        end else if (r_phase == PH_VALUE) begin
                            pri_valid     = 1'b1;
                            pri.kind      = K_VARINT;
                            pri.tag_field = r_field;
                            pri.tag_wire  = r_wire;
                            pri.value     = acc_new;
                            n_phase       = PH_TAG;
                        end else begin
                            pri_valid = 1'b1;
                            if (acc_new > 64'(MAX_MSG_BYTES)) begin
                                pri.kind       = K_ERROR;
                                pri.error_code = E_TRUNCATED;
                                n_stopped      = 1'b1;
                            end else begin
                                pri.kind      = K_LENGTH;
                                pri.tag_field = r_field;
                                pri.tag_wire  = r_wire;
                                pri.value     = acc_new;
                                n_remain      = acc_new[REM_W-1:0];
                                n_phase       = (acc_new == '0) ? PH_TAG : PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    n_remain         = rem_dec;
                    pri_valid        = 1'b1;
                    pri.kind         = K_PAYLOAD;
                    pri.tag_field    = r_field;
                    pri.tag_wire     = r_wire;
                    pri.payload_byte = b;
                    pri.payload_last = (rem_dec == '0);
                    if (rem_dec == '0) begin
                        n_phase = PH_TAG;
                    end
                end
                PH_SKIP: begin
                    n_remain = rem_dec;
                    if (rem_dec == '0) begin
                        pri_valid     = 1'b1;
                        pri.kind      = K_FIXED;
                        pri.tag_field = r_field;
                        pri.tag_wire  = r_wire;
                        pri.value     = (r_wire == WT_I64) ? 64'd8 : 64'd4;
                        n_phase       = PH_TAG;
                    end
                end
                default: begin
                    n_phase = PH_TAG;
                end
            endcase
        end

        o_entry.has_pri = pri_valid;
        o_entry.pri     = pri;
        o_entry.has_end = i_in.last_in_message && !n_stopped;
        o_entry.end_ok  = (n_phase == PH_TAG) && (n_cnt == '0);
        o_push          = accept && (pri_valid || o_entry.has_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_in.last_in_message)) begin
            r_phase   <= PH_TAG;
            r_acc     <= '0;
            r_cnt     <= '0;
            r_field   <= '0;
            r_wire    <= '0;
            r_remain  <= '0;
            r_stopped <= 1'b0;
        end else if (accept) begin
            r_phase   <= n_phase;
            r_acc     <= n_acc;
            r_cnt     <= n_cnt;
            r_field   <= n_field;
            r_wire    <= n_wire;
            r_remain  <= n_remain;
            r_stopped <= n_stopped;
        end
    end

endmodule

// File: hw/rtl/pwt_queue.sv
// ============================================================================
// pwt_queue: entry queue between parser and result emitter
// A small FIFO of per-byte entries, with head shown while not empty.
// ============================================================================
module pwt_queue
    import pwt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_entry o_head
);

    t_entry              r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/pwt_back.sv
// ============================================================================
// pwt_back: result emitter of the protobuf wire tokenizer
// Turns each queued entry into one or two result items in an output register.
// ============================================================================
module pwt_back
    import pwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_entry    i_head,
    output logic      o_pop,
    pwt_out_if.source o_out
);

    t_result r_out, n_out;
    logic    r_out_valid, n_out_valid;
    logic    r_second, n_second;
    logic    load;
    t_result end_item;

    assign load = !r_out_valid || o_out.ready;

    always_comb begin
        end_item            = '0;
        end_item.kind       = i_head.end_ok ? K_END_OK : K_ERROR;
        end_item.error_code = i_head.end_ok ? E_TOO_LONG : E_TRUNCATED;
        end_item.run_last   = 1'b1;

        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_second    = r_second;
        o_pop       = 1'b0;
        if (load) begin
            n_out_valid = i_q_valid;
            if (i_q_valid) begin
                if (i_head.has_pri && !r_second) begin
                    n_out          = i_head.pri;
                    n_out.run_last = !i_head.has_end;
                    if (i_head.has_end) begin
                        n_second = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_out    = end_item;
                    n_second = 1'b0;
                    o_pop    = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_second    <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            r_second    <= n_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kind         = r_out.kind;
    assign o_out.tag_field    = r_out.tag_field;
    assign o_out.tag_wire     = r_out.tag_wire;
    assign o_out.value        = r_out.value;
    assign o_out.payload_byte = r_out.payload_byte;
    assign o_out.payload_last = r_out.payload_last;
    assign o_out.error_code   = r_out.error_code;
    assign o_out.run_last     = r_out.run_last;

    // The head may not leave while its end item is still owed.
    a_second_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> i_q_valid)
        else $error("pending end item without a queued entry");

    a_second_two_items: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> (i_head.has_pri && i_head.has_end))
        else $error("pending end item on an entry with a single item");

    a_not_last_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.run_last) |-> r_second)
        else $error("non-final item shown but no end item owed");

endmodule

// File: hw/rtl/protobuf_wire_tokenizer.sv
// ============================================================================
// protobuf_wire_tokenizer: streaming protobuf wire-format tokenizer
// Splits an encoded message into varint fields, length headers, payload
// bytes, fixed-width skips, end and error items.
// ============================================================================
//
//   channel  | dir | handshake     | item
//   ---------+-----+---------------+---------------------------------------
//   i_in     | in  | valid / ready | data_byte, last_in_message
//   o_out    | out | valid / ready | kind, tag_field, tag_wire, value,
//            |     |               | payload_byte, payload_last,
//            |     |               | error_code, run_last
//
// The parser takes one byte every cycle as long as the four-entry queue has
// room; each byte's whole state update happens in that cycle.
// A byte causes zero, one or two result items. The emitter drains the queue
// one item per cycle through its output register while o_out is ready, so a
// byte with two items holds the queue head until its second item is loaded.
// A byte's first item goes through the queue, then the output register.
// Reset is synchronous and active low; it clears the parse state, the queue
// pointers and the output valid. The byte flagged last in a message also
// returns the parse state to its reset value.
// A stall on o_out fills the queue and then drops i_in.ready; the two sides
// otherwise run independently.
//
module protobuf_wire_tokenizer
    import pwt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    pwt_in_if.sink    i_in,
    pwt_out_if.source o_out
);

    // Front to queue.
    logic   push;
    t_entry push_entry;
    logic   q_full;

    // Queue to back.
    logic   q_valid;
    t_entry q_head;
    logic   pop;

    // The front part classifies each byte and decides every item it causes.
    pwt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    // The queue decouples input acceptance from output backpressure.
    pwt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // The back part serializes each entry into its result items.
    pwt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (q_head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
